@@ sv/kabf_pkg.sv @@
package kabf_pkg;

    localparam int W = 32;
    localparam int CFG_W = 25;
    localparam int DIV_STEPS = 56;

    localparam logic [1:0] REG_ANGLE_NOISE = 2'd0;
    localparam logic [1:0] REG_BIAS_NOISE  = 2'd1;
    localparam logic [1:0] REG_MEAS_NOISE  = 2'd2;

    localparam logic [CFG_W-1:0] RST_ANGLE_NOISE = 25'd16777;
    localparam logic [CFG_W-1:0] RST_BIAS_NOISE  = 25'd50332;
    localparam logic [CFG_W-1:0] RST_MEAS_NOISE  = 25'd503316;

    // datapath micro operations
    typedef enum logic [4:0] {
        OP_NONE,
        OP_RATE,     // rate = gyro - bias
        OP_MUL_A,    // angle += dt*rate
        OP_MUL_M,    // m = dt*p11
        OP_T,        // t = m - p01 - p10 + q_angle
        OP_MUL_T,    // p00 += dt*t
        OP_P01,      // p01 -= m, p10 -= m
        OP_MUL_B,    // p11 += qb*dt
        OP_S,        // s = p00 + r, y = meas - angle
        OP_DIV0,     // start k0 division
        OP_DIV1,     // start k1 division
        OP_MUL_K0Y,  // angle += k0*y
        OP_MUL_K1Y,  // bias += k1*y
        OP_MUL_C0,   // c0 = k0*p00
        OP_MUL_C1,   // c1 = k0*p01
        OP_MUL_C2,   // c2 = k1*p00
        OP_MUL_C3,   // c3 = k1*p01
        OP_COMMIT    // subtract corrections from covariance
    } t_op;

    typedef struct packed {
        logic load;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
    } t_status;

    function automatic logic signed [W-1:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7fffffff;
        if (v < -66'sd2147483648) return 32'sh80000000;
        return v[W-1:0];
    endfunction

endpackage

@@ sv/kabf_div.sv @@
module kabf_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic signed [kabf_pkg::W-1:0] i_num,
    input  logic signed [kabf_pkg::W-1:0] i_den,
    output logic                        o_busy,
    output logic signed [kabf_pkg::W-1:0] o_quot
);
    import kabf_pkg::*;

    logic [5:0]  r_cnt;
    logic        r_busy, r_neg, r_zero;
    logic [55:0] r_q;
    logic [32:0] r_rem;
    logic [32:0] r_den;
    logic [33:0] w_trial;
    logic [32:0] w_shift;
    logic [56:0] w_sq;

    assign w_shift = {r_rem[31:0], r_q[55]};
    assign w_trial = {1'b0, w_shift} - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'(DIV_STEPS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd1) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg  <= i_num[W-1] ^ i_den[W-1];
            r_zero <= (i_den == '0);
            r_q    <= {(i_num[W-1] ? 32'(-i_num) : 32'(i_num)), 24'd0};
            r_rem  <= '0;
            r_den  <= i_den[W-1] ? 33'(-{i_den[W-1], i_den}) : {1'b0, i_den};
        end else if (r_busy) begin
            if (!w_trial[33]) begin
                r_rem <= w_trial[32:0];
                r_q   <= {r_q[54:0], 1'b1};
            end else begin
                r_rem <= w_shift;
                r_q   <= {r_q[54:0], 1'b0};
            end
        end
    end

    // |num| up to 2^31 so the dividend magnitude is taken as unsigned
    assign w_sq = r_neg ? 57'(-{1'b0, r_q}) : {1'b0, r_q};
    assign o_busy = r_busy;
    assign o_quot = r_zero ? '0 : sat32(66'(signed'(w_sq)));
endmodule

@@ sv/kabf_datapath.sv @@
module kabf_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  kabf_pkg::t_cmd                i_cmd,
    output kabf_pkg::t_status             o_status,
    input  logic [26:0]                   i_meas,
    input  logic [30:0]                   i_gyro,
    input  logic [24:0]                   i_dt,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [kabf_pkg::CFG_W-1:0]    i_cfg_data,
    output logic signed [kabf_pkg::W-1:0] o_angle
);
    import kabf_pkg::*;

    logic signed [W-1:0] r_ang, r_bias, r_p00, r_p01, r_p10, r_p11;
    logic signed [W-1:0] r_rate, r_m, r_t, r_s, r_y, r_k0, r_k1;
    logic signed [W-1:0] r_c0, r_c1, r_c2, r_c3;
    logic signed [26:0]  r_meas;
    logic signed [30:0]  r_gyro;
    logic [24:0]         r_dt;
    logic [CFG_W-1:0]    r_qa, r_qb, r_r;
    logic                r_div_go, r_div_sel;
    logic signed [W:0]   w_ma, w_mb;
    logic signed [65:0]  w_p;
    logic signed [65:0]  w_round;
    logic signed [W-1:0] w_q, w_prod_now;
    logic                w_busy;
    logic                w_div_issue;
    t_op                 r_op_d;

    // one multiplier, operand selection per op
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (i_cmd.op)
            OP_MUL_A:   begin w_ma = 33'(signed'({1'b0, r_dt})); w_mb = 33'(r_rate); end
            OP_MUL_M:   begin w_ma = 33'(signed'({1'b0, r_dt})); w_mb = 33'(r_p11); end
            OP_MUL_T:   begin w_ma = 33'(signed'({1'b0, r_dt})); w_mb = 33'(r_t); end
            OP_MUL_B:   begin w_ma = 33'(signed'({1'b0, r_qb})); w_mb = 33'(signed'({1'b0, r_dt})); end
            OP_MUL_K0Y: begin w_ma = 33'(r_k0); w_mb = 33'(r_y); end
            OP_MUL_K1Y: begin w_ma = 33'(r_k1); w_mb = 33'(r_y); end
            OP_MUL_C0:  begin w_ma = 33'(r_k0); w_mb = 33'(r_p00); end
            OP_MUL_C1:  begin w_ma = 33'(r_k0); w_mb = 33'(r_p01); end
            OP_MUL_C2:  begin w_ma = 33'(r_k1); w_mb = 33'(r_p00); end
            OP_MUL_C3:  begin w_ma = 33'(r_k1); w_mb = 33'(r_p01); end
            default: ;
        endcase
    end

    assign w_p = 66'(w_ma * w_mb);
    assign w_round = (w_p + 66'sd8388608) >>> 24;
    assign w_prod_now = sat32(w_round);

    kabf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (r_div_sel ? r_p10 : r_p00),
        .i_den   (r_s),
        .o_busy  (w_busy),
        .o_quot  (w_q)
    );

    // first cycle of a divide op: the start pulse is not yet out
    assign w_div_issue = (i_cmd.op == OP_DIV0 && r_op_d != OP_DIV0)
                      || (i_cmd.op == OP_DIV1 && r_op_d != OP_DIV1);
    assign o_status.div_busy = w_busy | r_div_go | w_div_issue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qa <= RST_ANGLE_NOISE;
            r_qb <= RST_BIAS_NOISE;
            r_r  <= RST_MEAS_NOISE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ANGLE_NOISE: r_qa <= i_cfg_data;
                REG_BIAS_NOISE:  r_qb <= i_cfg_data;
                REG_MEAS_NOISE:  r_r  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ang <= '0; r_bias <= '0;
            r_p00 <= '0; r_p01 <= '0; r_p10 <= '0; r_p11 <= '0;
            r_op_d <= OP_NONE;
            r_div_go <= 1'b0;
            r_div_sel <= 1'b0;
        end else begin
            r_div_go <= 1'b0;
            r_op_d <= i_cmd.op;
            if (i_cmd.load) begin
                r_meas <= signed'(i_meas);
                r_gyro <= signed'(i_gyro);
                r_dt   <= i_dt;
            end
            // capture k0 once the first division is done; k1 is captured in the OP_MUL_K0Y step
            if (r_op_d == OP_DIV0 && i_cmd.op != OP_DIV0) r_k0 <= w_q;
            case (i_cmd.op)
                OP_RATE: r_rate <= sat32(66'(r_gyro) - 66'(r_bias));
                OP_MUL_A: r_ang <= sat32(66'(r_ang) + 66'(w_prod_now));
                OP_MUL_M: r_m <= w_prod_now;
                OP_T: r_t <= sat32(66'(r_m) - 66'(r_p01) - 66'(r_p10)
                               + 66'(signed'({1'b0, r_qa})));
                OP_MUL_T: r_p00 <= sat32(66'(r_p00) + 66'(w_prod_now));
                OP_P01: begin
                    r_p01 <= sat32(66'(r_p01) - 66'(r_m));
                    r_p10 <= sat32(66'(r_p10) - 66'(r_m));
                end
                OP_MUL_B: r_p11 <= sat32(66'(r_p11) + 66'(w_prod_now));
                OP_S: begin
                    r_s <= sat32(66'(r_p00) + 66'(signed'({1'b0, r_r})));
                    r_y <= sat32(66'(r_meas) - 66'(r_ang));
                end
                OP_DIV0: if (r_op_d != OP_DIV0) begin
                    r_div_go <= 1'b1; r_div_sel <= 1'b0;
                end
                OP_DIV1: if (r_op_d != OP_DIV1) begin
                    r_div_go <= 1'b1; r_div_sel <= 1'b1;
                end
                OP_MUL_K0Y: begin
                    if (r_op_d == OP_DIV1) r_k1 <= w_q;
                    r_ang <= sat32(66'(r_ang) + 66'(w_prod_now));
                end
                OP_MUL_K1Y: r_bias <= sat32(66'(r_bias) + 66'(w_prod_now));
                OP_MUL_C0: r_c0 <= w_prod_now;
                OP_MUL_C1: r_c1 <= w_prod_now;
                OP_MUL_C2: r_c2 <= w_prod_now;
                OP_MUL_C3: r_c3 <= w_prod_now;
                OP_COMMIT: begin
                    r_p00 <= sat32(66'(r_p00) - 66'(r_c0));
                    r_p01 <= sat32(66'(r_p01) - 66'(r_c1));
                    r_p10 <= sat32(66'(r_p10) - 66'(r_c2));
                    r_p11 <= sat32(66'(r_p11) - 66'(r_c3));
                end
                default: ;
            endcase
        end
    end

    assign o_angle = r_ang;
endmodule

@@ sv/kabf_ctrl.sv @@
module kabf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  kabf_pkg::t_status i_status,
    output kabf_pkg::t_cmd    o_cmd
);
    import kabf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state r_state, n_state;
    t_op    r_op, n_op;

    always_comb begin
        n_state = r_state;
        n_op = r_op;
        o_cmd.load = 1'b0;
        o_cmd.op = OP_NONE;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_RUN;
                    n_op = OP_RATE;
                end
            end
            S_RUN: begin
                o_cmd.op = r_op;
                // hold divide ops until the divider drains
                if (!((r_op == OP_DIV0 || r_op == OP_DIV1) && i_status.div_busy)) begin
                    if (r_op == OP_COMMIT) n_state = S_OUT;
                    else n_op = t_op'(r_op + 5'd1);
                end
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op <= OP_NONE;
        end else begin
            r_state <= n_state;
            r_op <= n_op;
        end
    end
endmodule

@@ sv/kalman_angle_bias_filter_core.sv @@
// two serial 56-step divisions dominate the run from request accept to result valid;
// one multiplier is shared by all products; requests are taken one at a time, a new one
// only after the previous result has been accepted on the output
// reset (synchronous, active low) clears state and covariance, loads default noise
module kalman_angle_bias_filter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,  // measured_angle[26:0], gyro_rate[57:27], time_step[82:58]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // filtered_angle[31:0]
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [24:0] i_cfg_data
);
    import kabf_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    kabf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    kabf_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .i_meas     (s_axis_tdata[26:0]),
        .i_gyro     (s_axis_tdata[57:27]),
        .i_dt       (s_axis_tdata[82:58]),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_angle    (m_axis_tdata)
    );
endmodule

@@ sv/kabf_checker.sv @@
module kabf_assert (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);
    // no new request while a result is pending
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("ready during output");
    // accept leads to busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready) else $error("not busy");
    // result not immediate
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> ##1 !m_axis_tvalid) else $error("early result");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata)) else $error("data moved");
endmodule

bind kalman_angle_bias_filter_core kabf_assert u_chk (.*);
